// File: rtl/rpcc_pkg.sv
// Shared types and constants for the colour classifier.
`default_nettype none
package rpcc_pkg;
   localparam int unsigned COUNT_WIDTH_DEF = 16;
   localparam int unsigned THR_WIDTH = 16;
   localparam int unsigned CLASS_WIDTH = 3;
   localparam int unsigned CSR_IDX_WIDTH = 2;
   localparam int unsigned LOW_LIMIT = 300;
   localparam int unsigned LOW_SUBST = 315;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_RED = 2'd0, CSR_GREEN = 2'd1, CSR_BLUE = 2'd2, CSR_NONE = 2'd3
   } csr_idx_type;

   typedef enum logic [CLASS_WIDTH-1:0] {
      CLS_RED = 3'd0, CLS_GREEN = 3'd1, CLS_BLUE = 3'd2, CLS_YELLOW = 3'd3,
      CLS_BROWN = 3'd4
   } class_type;

   // front -> back handshake status
   typedef struct packed {
      logic valid;
      logic ready;
   } hs_type;
endpackage
`default_nettype wire

// File: rtl/rpcc_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module rpcc_div #(
   parameter int unsigned NW = 40,
   parameter int unsigned DW = 34
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               done,
   output logic [NW-1:0]      quo
);
   localparam int unsigned CW = $clog2(NW + 1);
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic [CW-1:0] n_ff, n_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [DW:0]   trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; n_in = n_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[DW-1:0], q_ff[NW-1]};
      if (start) begin
         q_in = num; r_in = '0; d_in = den; n_in = CW'(NW); busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in = {q_ff[NW-2:0], 1'b0};
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in[0] = 1'b1;
         end else begin
            r_in = trial;
         end
         n_in = n_ff - CW'(1);
         if (n_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; n_ff <= n_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end
   assign done = done_ff;
   assign quo = q_ff;
endmodule
`default_nettype wire

// File: rtl/rpcc_front.sv
// Front: accepts a word, clamps counts, queues a two-deep job list.
`default_nettype none
module rpcc_front #(
   parameter int unsigned COUNT_WIDTH = rpcc_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [63:0] in_data,
   output logic             job_valid,
   input  wire logic        job_pop,
   output logic [4*COUNT_WIDTH-1:0] job_counts
);
   import rpcc_pkg::*;
   localparam int unsigned CW = COUNT_WIDTH;
   logic [4*CW-1:0] q_ff [2];
   logic [4*CW-1:0] cl;
   logic [1:0] cnt_ff, cnt_in;
   logic wp_ff, rp_ff;
   logic push;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         logic [CW-1:0] v;
         v = CW'(in_data[16*i +: 16]);
         cl[CW*i +: CW] = (v < CW'(LOW_LIMIT)) ? CW'(LOW_SUBST) : v;
      end
   end

   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign job_counts = q_ff[rp_ff];
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, job_pop && job_valid};

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= cl;
      if (reset) begin
         cnt_ff <= '0; wp_ff <= 1'b0; rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= !wp_ff;
         if (job_pop && job_valid) rp_ff <= !rp_ff;
      end
   end
endmodule
`default_nettype wire

// File: rtl/rpcc_back.sv
// Back: shares and clear ratios by one shared divider, then windows/tree.
`default_nettype none
module rpcc_back #(
   parameter int unsigned COUNT_WIDTH = rpcc_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        job_valid,
   output logic             job_pop,
   input  wire logic [4*COUNT_WIDTH-1:0] job_counts,
   input  wire logic [15:0] red_thr,
   input  wire logic [15:0] green_thr,
   input  wire logic [15:0] blue_thr,
   output logic             out_valid,
   input  wire logic        out_ready,
   output logic [7:0]       out_data
);
   import rpcc_pkg::*;
   localparam int unsigned CW = COUNT_WIDTH;
   localparam int unsigned NW = CW + 7;
   localparam int unsigned DW = CW + 2;
   logic [CW-1:0] ch_ff [4];
   logic [DW-1:0] sum_ff;
   logic [NW-1:0] res_ff [6];
   logic [2:0] idx_ff, idx_in;
   logic busy_ff, busy_in, issue_ff, issue_in;
   logic ov_ff, ov_in;
   logic [CLASS_WIDTH-1:0] cls_ff;
   logic rng_ff;
   logic start, done;
   logic [NW-1:0] num, quo;
   logic [DW-1:0] den;
   logic [CW-1:0] numsrc;
   logic [2:0] sel;
   logic [CLASS_WIDTH-1:0] cls;
   logic rng, pr, pg, pb;
   logic [CLASS_WIDTH-1:0] fb;
   logic finish;

   // jobs 0..2: share of r,g,b over sum; 3..5: clear over r,g,b
   always_comb begin
      sel = (idx_ff > 3'd2) ? (idx_ff - 3'd3) : idx_ff;
      numsrc = (idx_ff > 3'd2) ? ch_ff[3] : ch_ff[sel[1:0]];
      num = NW'(numsrc) * NW'(100);
      den = (idx_ff > 3'd2) ? DW'(ch_ff[sel[1:0]]) : sum_ff;
   end
   assign start = issue_ff;

   rpcc_div #(.NW(NW), .DW(DW)) u_div (
      .clock, .reset, .start, .num, .den, .done, .quo
   );

   function automatic logic win(input logic [NW-1:0] v, input int unsigned lo,
                                input int unsigned hi);
      return (v > NW'(lo)) && (v < NW'(hi));
   endfunction

   always_comb begin
      rng = 1'b1;
      priority if (win(res_ff[0],29,32) && win(res_ff[1],36,38) && win(res_ff[2],30,32))
         cls = CLS_RED;
      else if (win(res_ff[0],33,35) && win(res_ff[1],32,35) && win(res_ff[2],30,32))
         cls = CLS_GREEN;
      else if (win(res_ff[0],34,37) && win(res_ff[1],34,36) && win(res_ff[2],27,29))
         cls = CLS_BLUE;
      else if (win(res_ff[0],30,34) && win(res_ff[1],33,35) && win(res_ff[2],31,35))
         cls = CLS_YELLOW;
      else if (win(res_ff[0],31,34) && win(res_ff[1],34,36) && win(res_ff[2],29,32))
         cls = CLS_BROWN;
      else if (win(res_ff[0],27,31) && win(res_ff[1],35,41) && win(res_ff[2],30,33))
         cls = CLS_RED;
      else begin
         cls = CLS_BROWN;
         rng = 1'b0;
      end
   end
   assign pr = res_ff[3] > NW'(red_thr);
   assign pg = res_ff[4] > NW'(green_thr);
   assign pb = res_ff[5] > NW'(blue_thr);

   always_comb begin
      priority if (pr) fb = pg ? (pb ? CLS_RED : CLS_YELLOW) : CLS_RED;
      else if (pg) fb = CLS_GREEN;
      else if (pb) fb = CLS_BLUE;
      else fb = CLS_BROWN;
   end

   // idx 6: all six quotients stored, post once the output register is free
   assign finish = busy_ff && (idx_ff == 3'd6) && (!ov_ff || out_ready);
   assign job_pop = job_valid && !busy_ff;

   always_comb begin
      busy_in = busy_ff; issue_in = 1'b0; idx_in = idx_ff; ov_in = ov_ff;
      if (out_valid && out_ready) ov_in = 1'b0;
      if (job_pop) begin
         busy_in = 1'b1; idx_in = '0; issue_in = 1'b1;
      end else if (finish) begin
         ov_in = 1'b1; busy_in = 1'b0; idx_in = '0;
      end else if (done) begin
         idx_in = idx_ff + 3'd1;
         issue_in = (idx_ff != 3'd5);
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         for (int i = 0; i < 4; i++) ch_ff[i] <= job_counts[CW*i +: CW];
         sum_ff <= DW'(job_counts[0 +: CW]) + DW'(job_counts[CW +: CW])
                   + DW'(job_counts[2*CW +: CW]);
      end
      if (done) res_ff[idx_ff] <= quo;
      if (finish) begin
         cls_ff <= rng ? cls : fb;
         rng_ff <= rng;
      end
      if (reset) begin
         busy_ff <= 1'b0; issue_ff <= 1'b0; idx_ff <= '0; ov_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; issue_ff <= issue_in; idx_ff <= idx_in; ov_ff <= ov_in;
      end
   end

   assign out_valid = ov_ff;
   assign out_data = {4'b0, rng_ff, cls_ff};
endmodule
`default_nettype wire

// File: rtl/rgb_period_colour_classifier.sv
// Top level of the RGB period colour classifier.
//
// channel  dir  tdata fields (low bit first)
// req_     in   red_count[15:0] green_count[31:16] blue_count[47:32] clear_count[63:48]
// rsp_     out  colour_class[2:0] matched_by_range[3]
// csr_     in   index 0 red, 1 green, 2 blue threshold
//
// The back takes no new word until the last one is through: one shared
// bit-serial divider does six divisions of COUNT_WIDTH+7 quotient bits in turn.
// A two-word queue lets the front keep accepting while the back computes,
// and the result register lets the next word start while rsp_ stalls.
// Reset is synchronous, active high; thresholds return to 43/46/58.
`default_nettype none
module rgb_period_colour_classifier #(
   parameter int unsigned COUNT_WIDTH = rpcc_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // red, green, blue, clear counts
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // colour_class, matched_by_range
   input  wire logic        csr_we,
   input  wire logic [rpcc_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [15:0] csr_wdata
);
   import rpcc_pkg::*;
   logic [15:0] red_ff, green_ff, blue_ff;
   logic job_valid, job_pop;
   logic [4*COUNT_WIDTH-1:0] job_counts;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff <= 16'd43; green_ff <= 16'd46; blue_ff <= 16'd58;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_RED:   red_ff <= csr_wdata;
            CSR_GREEN: green_ff <= csr_wdata;
            CSR_BLUE:  blue_ff <= csr_wdata;
            default:   ;
         endcase
      end
   end

   rpcc_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_data(req_tdata), .job_valid, .job_pop, .job_counts
   );

   rpcc_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
      .clock, .reset, .job_valid, .job_pop, .job_counts,
      .red_thr(red_ff), .green_thr(green_ff), .blue_thr(blue_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(rsp_tdata)
   );

   a_cls_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= 3'd4) else $error("bad class");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:4] == 4'd0) else $error("pad bits set");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> job_valid) else $error("pop of empty queue");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled word changed");
endmodule
`default_nettype wire
